FILE: sv/qof_pkg.sv
// ----------------------------------------------------------------------------
// qof_pkg
// Shared widths, codes and controller/datapath bundles for the outline
// flattener.
// ----------------------------------------------------------------------------
package qof_pkg;

  localparam int CW       = 26;  // vertex coordinate width, 8 fraction bits
  localparam int IW       = 16;  // input point width
  localparam int PW       = 17;  // point width after y negation
  localparam int CFG_W    = 6;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;
  localparam int DIVCNT_W = $clog2(CW + 1);

  localparam logic [CFG_W-1:0] STEPS_RST = 6'd32;

  // register index as seen on paddr[ADDR_W-1]
  localparam logic REG_CURVE_STEPS = 1'b0;

  // blend accumulation phases
  localparam logic [1:0] PH_A   = 2'd0;  // weight (N-k)^2 with pen
  localparam logic [1:0] PH_B   = 2'd1;  // weight 2k(N-k) with control
  localparam logic [1:0] PH_C   = 2'd2;  // weight k^2 with anchor
  localparam logic [1:0] PH_ACC = 2'd3;  // last product only

  typedef struct packed {
    logic       accept;
    logic       put_direct;
    logic       put_curve;
    logic       last;
    logic       contour_last;
    logic       seg_init;
    logic       seg_sel2;
    logic       k_inc;
    logic       mul_en;
    logic [1:0] mul_phase;
    logic       div_init;
    logic       div_step;
  } qof_cmd_t;

  typedef struct packed {
    logic job_direct;
    logic job_seg1;
    logic job_seg2;
    logic contour_end;
    logic k_last;
    logic out_free;
  } qof_sts_t;

endpackage

FILE: sv/qof_if.sv
// ----------------------------------------------------------------------------
// qof_pt_if / qof_vtx_if
// Valid/ready channels for outline points and polyline vertices.
// ----------------------------------------------------------------------------
interface qof_pt_if;
  import qof_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [IW-1:0] point_x;
  logic signed [IW-1:0] point_y;
  logic                 on_curve;
  logic                 contour_end;

  modport source(output valid, point_x, point_y, on_curve, contour_end, input ready);
  modport sink(input valid, point_x, point_y, on_curve, contour_end, output ready);
endinterface

interface qof_vtx_if;
  import qof_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] vertex_x;
  logic signed [CW-1:0] vertex_y;
  logic                 contour_last;
  logic                 run_last;

  modport source(output valid, vertex_x, vertex_y, contour_last, run_last, input ready);
  modport sink(input valid, vertex_x, vertex_y, contour_last, run_last, output ready);
endinterface

FILE: sv/quadratic_outline_flattener.sv
// ----------------------------------------------------------------------------
// quadratic_outline_flattener
// Turns quadratic glyph outline points into polyline vertices.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  pt_i      in   valid/ready          point_x, point_y, on_curve, contour_end
//  vtx_o     out  valid/ready          vertex_x, vertex_y, contour_last, run_last
//  apb       in   psel/penable/pready  curve_steps at byte address 0
//
// One item at a time. A direct vertex is loaded straight into the output
// register; each curve point runs 4 multiply-accumulate phases, the bit-serial
// divide by 2N^2 and a load of the output register, after a setup per segment.
// A stalled output holds the sequencer at its next vertex. Async low reset.
// ----------------------------------------------------------------------------
module quadratic_outline_flattener #(
  parameter int MAX_STEPS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qof_pkg::ADDR_W-1:0]   paddr,
  input  logic [qof_pkg::DATA_W-1:0]   pwdata,
  output logic [qof_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  qof_pt_if.sink                       pt_i,
  qof_vtx_if.source                    vtx_o
);
  import qof_pkg::*;

  logic [CFG_W-1:0] steps_q;
  qof_cmd_t         cmd;
  qof_sts_t         sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= STEPS_RST;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_CURVE_STEPS) begin
      steps_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[ADDR_W-1] == REG_CURVE_STEPS) ? DATA_W'(steps_q) : '0;

  qof_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pt_i.valid),
    .in_ready_o (pt_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qof_dp #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_steps_i    (steps_q),
    .point_x_i      (pt_i.point_x),
    .point_y_i      (pt_i.point_y),
    .on_curve_i     (pt_i.on_curve),
    .contour_end_i  (pt_i.contour_end),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .vtx_valid_o    (vtx_o.valid),
    .vtx_ready_i    (vtx_o.ready),
    .vertex_x_o     (vtx_o.vertex_x),
    .vertex_y_o     (vtx_o.vertex_y),
    .contour_last_o (vtx_o.contour_last),
    .run_last_o     (vtx_o.run_last)
  );

endmodule

FILE: sv/qof_ctrl.sv
// ----------------------------------------------------------------------------
// qof_ctrl
// Sequencer: direct vertex, then up to two flattened segments, each point
// as multiply-accumulate phases followed by a bit-serial divide.
// ----------------------------------------------------------------------------
module qof_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qof_pkg::qof_sts_t   sts_i,
  output qof_pkg::qof_cmd_t   cmd_o
);
  import qof_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIRECT = 6'b000010,
    S_INIT   = 6'b000100,
    S_MUL    = 6'b001000,
    S_DIV    = 6'b010000,
    S_PUT    = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic                jd_q, jd_d, j1_q, j1_d, j2_q, j2_d;
  logic                end_q, end_d, seg2_q, seg2_d;
  logic [1:0]          ph_q, ph_d;
  logic [DIVCNT_W-1:0] dc_q, dc_d;

  always_comb begin
    state_d    = state_q;
    jd_d       = jd_q;
    j1_d       = j1_q;
    j2_d       = j2_q;
    end_d      = end_q;
    seg2_d     = seg2_q;
    ph_d       = ph_q;
    dc_d       = dc_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          jd_d   = sts_i.job_direct;
          j1_d   = sts_i.job_seg1;
          j2_d   = sts_i.job_seg2;
          end_d  = sts_i.contour_end;
          seg2_d = ~sts_i.job_seg1;
          if (sts_i.job_direct) begin
            state_d = S_DIRECT;
          end else if (sts_i.job_seg1 || sts_i.job_seg2) begin
            state_d = S_INIT;
          end
        end
      end
      S_DIRECT: begin
        if (sts_i.out_free) begin
          cmd_o.put_direct   = 1'b1;
          cmd_o.last         = ~(j1_q | j2_q);
          cmd_o.contour_last = ~(j1_q | j2_q) & end_q;
          jd_d               = 1'b0;
          state_d            = (j1_q || j2_q) ? S_INIT : S_IDLE;
        end
      end
      S_INIT: begin
        // pen is settled here, in the cycle after the previous beat was loaded
        cmd_o.seg_init = 1'b1;
        cmd_o.seg_sel2 = seg2_q;
        ph_d           = PH_A;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_phase = ph_q;
        ph_d            = ph_q + 2'd1;
        if (ph_q == PH_ACC) begin
          dc_d    = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_init = (dc_q == '0);
        cmd_o.div_step = (dc_q != '0);
        dc_d           = dc_q + DIVCNT_W'(1);
        if (dc_q == DIVCNT_W'(CW)) begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        if (sts_i.out_free) begin
          cmd_o.put_curve    = 1'b1;
          cmd_o.last         = sts_i.k_last & (seg2_q | ~j2_q);
          cmd_o.contour_last = sts_i.k_last & (seg2_q | ~j2_q) & end_q;
          if (!sts_i.k_last) begin
            cmd_o.k_inc = 1'b1;
            ph_d        = PH_A;
            state_d     = S_MUL;
          end else if (!seg2_q && j2_q) begin
            seg2_d  = 1'b1;
            state_d = S_INIT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      jd_q    <= 1'b0;
      j1_q    <= 1'b0;
      j2_q    <= 1'b0;
      end_q   <= 1'b0;
      seg2_q  <= 1'b0;
      ph_q    <= PH_A;
      dc_q    <= '0;
    end else begin
      state_q <= state_d;
      jd_q    <= jd_d;
      j1_q    <= j1_d;
      j2_q    <= j2_d;
      end_q   <= end_d;
      seg2_q  <= seg2_d;
      ph_q    <= ph_d;
      dc_q    <= dc_d;
    end
  end

`ifndef SYNTH
  a_put_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.put_curve || cmd_o.put_direct) |-> sts_i.out_free)
    else $error("vertex loaded into occupied output register");

  a_nojob_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && !sts_i.job_direct && !sts_i.job_seg1 && !sts_i.job_seg2)
    |=> state_q == S_IDLE)
    else $error("item without results left the idle state");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && dc_q == DIVCNT_W'(CW)) |=> state_q == S_PUT)
    else $error("divide did not hand over after full quotient");

  a_seg2_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT && seg2_q) |-> j2_q)
    else $error("closing segment started without request");
`endif

endmodule

FILE: sv/qof_dp.sv
// ----------------------------------------------------------------------------
// qof_dp
// Outline state, blend multiply-accumulate, restoring divider and the
// vertex output register.
// ----------------------------------------------------------------------------
module qof_dp #(
  parameter int MAX_STEPS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [qof_pkg::CFG_W-1:0]    cfg_steps_i,
  input  logic signed [qof_pkg::IW-1:0] point_x_i,
  input  logic signed [qof_pkg::IW-1:0] point_y_i,
  input  logic                         on_curve_i,
  input  logic                         contour_end_i,
  input  qof_pkg::qof_cmd_t            cmd_i,
  output qof_pkg::qof_sts_t            sts_o,
  output logic                         vtx_valid_o,
  input  logic                         vtx_ready_i,
  output logic signed [qof_pkg::CW-1:0] vertex_x_o,
  output logic signed [qof_pkg::CW-1:0] vertex_y_o,
  output logic                         contour_last_o,
  output logic                         run_last_o
);
  import qof_pkg::*;

  localparam int NW = $clog2(MAX_STEPS + 1);
  localparam int WW = 2 * NW + 1;
  localparam int AW = CW + WW;
  localparam int DW = 2 * NW + 1;

  // outline state
  logic [CW-1:0] pen_q[2], first_q[2];
  logic [PW-1:0] ctrl_q[2];
  logic          hf_q, hc_q;

  // per-item and per-segment operands
  logic [CW-1:0] dir_q[2], s1c_q[2], s1a_q[2];
  logic [CW-1:0] p0_q[2], c_q[2], p2_q[2];
  logic [NW-1:0] k_q;
  logic [2*NW-1:0] d_q;
  logic [WW-1:0] w_q;
  logic [1:0]    csel_q;
  logic [AW-1:0] acc_q[2];
  logic [DW-1:0] rem_q[2];
  logic [CW-1:0] qr_q[2];

  // output register
  logic          ovalid_q;
  logic [CW-1:0] ox_q, oy_q;
  logic          oclast_q, orlast_q;

  logic [NW-1:0]   n, m;
  logic [2*NW-1:0] mm, km, kk;
  logic [WW-1:0]   wgt;
  logic [PW-1:0]   pin[2];
  logic [PW:0]     msum[2];
  logic [CW-1:0]   f[2], mid[2], cx8[2], anchor[2], csel_v[2], qres[2];
  logic [AW-1:0]   prod[2], dvd[2];
  logic [DW-1:0]   dv, rem_n[2];
  logic [DW:0]     t[2], tsub[2];
  logic            ge[2];
  logic            job_direct;

  always_comb begin
    if (cfg_steps_i == '0) begin
      n = NW'(1);
    end else if (cfg_steps_i > CFG_W'(MAX_STEPS)) begin
      n = NW'(MAX_STEPS);
    end else begin
      n = cfg_steps_i[NW-1:0];
    end
  end

  assign pin[0] = {point_x_i[IW-1], point_x_i};
  assign pin[1] = PW'(0) - {point_y_i[IW-1], point_y_i};

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      f[i]      = {{(CW-PW-8){pin[i][PW-1]}}, pin[i], 8'b0};
      msum[i]   = {ctrl_q[i][PW-1], ctrl_q[i]} + {pin[i][PW-1], pin[i]};
      mid[i]    = {{(CW-PW-8){msum[i][PW]}}, msum[i], 7'b0};
      cx8[i]    = {ctrl_q[i][PW-1], ctrl_q[i], 8'b0};
      anchor[i] = on_curve_i ? f[i] : mid[i];
    end
  end

  assign job_direct = ~hc_q & (on_curve_i | ~hf_q);

  always_comb begin
    sts_o             = '0;
    sts_o.job_direct  = job_direct;
    sts_o.job_seg1    = hc_q;
    sts_o.job_seg2    = contour_end_i & ~on_curve_i;
    sts_o.contour_end = contour_end_i;
    sts_o.k_last      = (k_q == n);
    sts_o.out_free    = ~ovalid_q | vtx_ready_i;
  end

  // blend weights for the current k
  assign m  = n - k_q;
  assign mm = m * m;
  assign km = k_q * m;
  assign kk = k_q * k_q;

  always_comb begin
    case (cmd_i.mul_phase)
      PH_A:    wgt = {1'b0, mm};
      PH_B:    wgt = {km, 1'b0};
      PH_C:    wgt = {1'b0, kk};
      default: wgt = '0;
    endcase
  end

  // coordinates enter the divider offset by 2^(CW-1) so all terms are unsigned
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      case (csel_q)
        PH_A:    csel_v[i] = p0_q[i];
        PH_B:    csel_v[i] = c_q[i];
        PH_C:    csel_v[i] = p2_q[i];
        default: csel_v[i] = '0;
      endcase
      prod[i] = w_q * {~csel_v[i][CW-1], csel_v[i][CW-2:0]};
      dvd[i]  = {acc_q[i][AW-2:0], 1'b0} + AW'(d_q);
      t[i]    = {rem_q[i], qr_q[i][CW-1]};
      tsub[i] = t[i] - {1'b0, dv};
      ge[i]   = (t[i] >= {1'b0, dv});
      rem_n[i] = ge[i] ? tsub[i][DW-1:0] : t[i][DW-1:0];
      qres[i] = {~qr_q[i][CW-1], qr_q[i][CW-2:0]};
    end
  end

  assign dv = {d_q, 1'b0};

  // outline state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        pen_q[i]   <= '0;
        first_q[i] <= '0;
        ctrl_q[i]  <= '0;
      end
      hf_q <= 1'b0;
      hc_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        for (int i = 0; i < 2; i++) begin
          if (!on_curve_i) begin
            ctrl_q[i] <= pin[i];
          end
          if (job_direct && !hf_q) begin
            first_q[i] <= f[i];
          end
        end
        hc_q <= ~on_curve_i & ~contour_end_i;
        if (contour_end_i) begin
          hf_q <= 1'b0;
        end else if (job_direct) begin
          hf_q <= 1'b1;
        end
      end
      for (int i = 0; i < 2; i++) begin
        if (cmd_i.put_direct) begin
          pen_q[i] <= dir_q[i];
        end else if (cmd_i.put_curve) begin
          pen_q[i] <= qres[i];
        end
      end
    end
  end

  // operands and arithmetic
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 2; i++) begin
      if (cmd_i.accept) begin
        dir_q[i] <= f[i];
        s1c_q[i] <= cx8[i];
        s1a_q[i] <= anchor[i];
      end
      if (cmd_i.seg_init) begin
        p0_q[i] <= pen_q[i];
        c_q[i]  <= cmd_i.seg_sel2 ? cx8[i] : s1c_q[i];
        p2_q[i] <= cmd_i.seg_sel2 ? first_q[i] : s1a_q[i];
      end
      if (cmd_i.mul_en && cmd_i.mul_phase != PH_A) begin
        acc_q[i] <= ((cmd_i.mul_phase == PH_B) ? '0 : acc_q[i]) + prod[i];
      end
      if (cmd_i.div_init) begin
        rem_q[i] <= dvd[i][AW-1:CW];
        qr_q[i]  <= dvd[i][CW-1:0];
      end else if (cmd_i.div_step) begin
        rem_q[i] <= rem_n[i];
        qr_q[i]  <= {qr_q[i][CW-2:0], ge[i]};
      end
    end
    if (cmd_i.seg_init) begin
      k_q <= NW'(1);
      d_q <= n * n;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + NW'(1);
    end
    if (cmd_i.mul_en) begin
      w_q    <= wgt;
      csel_q <= cmd_i.mul_phase;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.put_direct || cmd_i.put_curve) begin
      ovalid_q <= 1'b1;
    end else if (vtx_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.put_direct || cmd_i.put_curve) begin
      ox_q     <= cmd_i.put_direct ? dir_q[0] : qres[0];
      oy_q     <= cmd_i.put_direct ? dir_q[1] : qres[1];
      oclast_q <= cmd_i.contour_last;
      orlast_q <= cmd_i.last;
    end
  end

  assign vtx_valid_o    = ovalid_q;
  assign vertex_x_o     = ox_q;
  assign vertex_y_o     = oy_q;
  assign contour_last_o = oclast_q;
  assign run_last_o     = orlast_q;

endmodule
